// File: src/htfd_pkg.sv
`default_nettype none

package htfd_pkg;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'h00;
    localparam logic [15:0] STATUS_MASK = 16'hFFFC;

    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_OFFSET = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_GAIN   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HUM_OFFSET  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HUM_GAIN    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ERROR_VALUE = 3'd4;

    localparam logic [15:0] TEMP_OFFSET_RST = 16'hEDC7;  // -4665
    localparam logic [15:0] TEMP_GAIN_RST   = 16'd17572;
    localparam logic [15:0] HUM_OFFSET_RST  = 16'hFDA8;  // -600
    localparam logic [15:0] HUM_GAIN_RST    = 16'd12500;
    localparam logic [15:0] ERROR_VALUE_RST = 16'hD8F1;  // -9999

    typedef struct packed {
        logic signed [15:0] temp_offset;
        logic [15:0]        temp_gain;
        logic signed [15:0] hum_offset;
        logic [15:0]        hum_gain;
        logic signed [15:0] error_value;
    } cfg_t;

    // one byte through the msb-first crc-8 shift register
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: src/humidity_temp_frame_decoder.sv
`default_nettype none

// channel   signals                                          direction
// in        in_valid, in_ready, high_byte, low_byte,         sink
//           check_byte, operation
// out       out_valid, out_ready, value, crc_error           source
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data        sink, always ready
//
// four register stages: crc of the high byte, crc of the low byte and compare,
// 16x16 multiply, offset add into the output register
// one transaction per cycle while out_ready holds; out_valid is the valid bit of the last stage
// reset clears the stage valid bits and loads the default register values
// each stage holds while the one after it is full and stalled; bubbles collapse

module humidity_temp_frame_decoder
    import htfd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   in_valid,
    output      logic                   in_ready,
    input  wire logic [7:0]             high_byte,
    input  wire logic [7:0]             low_byte,
    input  wire logic [7:0]             check_byte,
    input  wire logic                   operation,

    output      logic                   out_valid,
    input  wire logic                   out_ready,
    output      logic signed [17:0]     value,
    output      logic                   crc_error,

    input  wire logic                   cfg_valid,
    output      logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [15:0]            cfg_data
);

    cfg_t cfg;

    assign cfg_ready = 1'b1;

    htfd_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // stage valid bits
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_load, s2_load, s3_load, s4_load;

    assign s4_load  = !s4_valid_reg || out_ready;
    assign s3_load  = !s3_valid_reg || s4_load;
    assign s2_load  = !s2_valid_reg || s3_load;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign in_ready = s1_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_load)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_load)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_load)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // stage 1: crc over the high byte
    logic [7:0]  s1_crc_reg;
    logic [7:0]  s1_low_reg;
    logic [7:0]  s1_high_reg;
    logic [7:0]  s1_check_reg;
    logic        s1_op_reg;

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_crc_reg   <= crc8_byte(CRC_INIT, high_byte);
            s1_high_reg  <= high_byte;
            s1_low_reg   <= low_byte;
            s1_check_reg <= check_byte;
            s1_op_reg    <= operation;
        end
    end

    // stage 2: finish crc, compare, pick the coefficients
    logic [7:0]         s2_crc_next;
    logic               s2_err_reg;
    logic [15:0]        s2_raw_reg;
    logic [15:0]        s2_gain_reg;
    logic signed [15:0] s2_offset_reg;

    assign s2_crc_next = crc8_byte(s1_crc_reg, s1_low_reg);

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_err_reg    <= (s2_crc_next != s1_check_reg);
            s2_raw_reg    <= {s1_high_reg, s1_low_reg} & STATUS_MASK;
            s2_gain_reg   <= s1_op_reg ? cfg.hum_gain : cfg.temp_gain;
            s2_offset_reg <= s1_op_reg ? cfg.hum_offset : cfg.temp_offset;
        end
    end

    // stage 3: unsigned 16x16 product
    logic [31:0]        s3_prod_reg;
    logic               s3_err_reg;
    logic signed [15:0] s3_offset_reg;

    always_ff @(posedge clk)
    begin
        if (s3_load)
        begin
            s3_prod_reg   <= s2_gain_reg * s2_raw_reg;
            s3_err_reg    <= s2_err_reg;
            s3_offset_reg <= s2_offset_reg;
        end
    end

    // stage 4: floor of product / 65536 plus offset, or error value
    logic signed [17:0] s4_value_next;
    logic signed [17:0] s4_value_reg;
    logic               s4_err_reg;

    always_comb
    begin
        if (s3_err_reg)
        begin
            s4_value_next = {{2{cfg.error_value[15]}}, cfg.error_value};
        end
        else
        begin
            s4_value_next = $signed({{2{s3_offset_reg[15]}}, s3_offset_reg})
                          + $signed({2'b00, s3_prod_reg[31:16]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_load)
        begin
            s4_value_reg <= s4_value_next;
            s4_err_reg   <= s3_err_reg;
        end
    end

    assign out_valid = s4_valid_reg;
    assign value     = s4_value_reg;
    assign crc_error = s4_err_reg;

endmodule

`default_nettype wire

// File: src/htfd_cfg_regs.sv
`default_nettype none

module htfd_cfg_regs
    import htfd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   wr_en,
    input  wire logic [CFG_INDEX_W-1:0] wr_index,
    input  wire logic [15:0]            wr_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.temp_offset <= TEMP_OFFSET_RST;
            cfg_reg.temp_gain   <= TEMP_GAIN_RST;
            cfg_reg.hum_offset  <= HUM_OFFSET_RST;
            cfg_reg.hum_gain    <= HUM_GAIN_RST;
            cfg_reg.error_value <= ERROR_VALUE_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_TEMP_OFFSET: cfg_reg.temp_offset <= wr_data;
                REG_TEMP_GAIN:   cfg_reg.temp_gain   <= wr_data;
                REG_HUM_OFFSET:  cfg_reg.hum_offset  <= wr_data;
                REG_HUM_GAIN:    cfg_reg.hum_gain    <= wr_data;
                REG_ERROR_VALUE: cfg_reg.error_value <= wr_data;
                default:         ;  // unknown index, write dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire
